/* rtl/core/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// Sine stepper position follower package
// Shared constants, types and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package ssp_pkg;

  // Phase accumulator and sine table geometry.
  localparam int PHASE_BITS       = 32;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int IDX_BITS         = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR_BITS         = IDX_BITS - 2;
  localparam int QTR_DEPTH        = 1 << QTR_BITS;

  // Field widths.
  localparam int MODE_W   = 2;
  localparam int FREQ_W   = 10;
  localparam int AMP_W    = 15;
  localparam int OFS_W    = 13;
  localparam int ELAPSED_W = 16;
  localparam int CFG_W    = 15;
  localparam int OFSNOW_W = 18;
  localparam int COUNT_W  = 22;
  localparam int SINE_W   = 16;

  // Register limits.
  localparam logic [FREQ_W-1:0]        FREQ_TOP    = 10'd1000;
  localparam logic [FREQ_W-1:0]        FREQ_RESET  = 10'd100;
  localparam logic [AMP_W-1:0]         AMP_MAX     = 15'd20000;
  localparam logic [AMP_W-1:0]         AMP_RESET   = 15'd10;
  localparam logic signed [OFS_W-1:0]  OFS_LIM_POS = 13'sd4000;
  localparam logic signed [OFS_W-1:0]  OFS_LIM_NEG = -13'sd4000;

  // Phase increment divider: freq * elapsed * 2^PHASE_BITS / 10^8.
  localparam int PROD_W = FREQ_W + ELAPSED_W;
  localparam int REM_W  = 27;
  localparam logic [REM_W-1:0] PHASE_DIVISOR = 27'd100000000;

  // Target scaling: target = (|D| * TGT_K) >> TGT_SHIFT, TGT_K = 2^32 / (10 pi).
  localparam int DISP_W    = 36;
  localparam int MAG_W     = 34;
  localparam int K_W       = 28;
  localparam logic [K_W-1:0] TGT_K = 28'd136713055;
  localparam int TGT_SHIFT = 25;
  localparam int MQ_W      = K_W + MAG_W - TGT_SHIFT;
  localparam int TGT_W     = MQ_W + 1;
  localparam int CMP_W     = 40;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 22'sh1FFFFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 22'sh200000;

  typedef enum logic [MODE_W-1:0] {
    MODE_SINE,
    MODE_PULSE,
    MODE_ZERO,
    MODE_RELEASE
  } run_mode_t;

  typedef enum logic [1:0] {
    REG_RUN_MODE,
    REG_FREQ,
    REG_AMP,
    REG_OFFSET
  } cfg_reg_t;

  localparam logic [1:0] DIR_HOLD = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BACK = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADV,
    ST_LOOKUP,
    ST_SCALE,
    ST_ABS,
    ST_MUL,
    ST_SIGN,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef logic [14:0] sine_qtr_t [QTR_DEPTH];

  // One quarter-wave entry: Taylor series to x^11 in Q30, rounded to Q15.
  function automatic logic [14:0] sine_qtr_entry(input int unsigned j);
    logic [63:0] f;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] v;
    f  = 64'(j) << (30 - QTR_BITS);
    x  = (f * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t  = 64'd1073741824;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd110;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
    v  = (x * t) >> 30;
    v  = (v * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

  function automatic sine_qtr_t build_sine_qtr();
    sine_qtr_t tab;
    for (int k = 0; k < QTR_DEPTH; k++) begin
      tab[k] = sine_qtr_entry(k);
    end
    return tab;
  endfunction

  localparam sine_qtr_t     SINE_QTR  = build_sine_qtr();
  localparam logic [14:0]   SINE_PEAK = sine_qtr_entry(QTR_DEPTH);

endpackage

/* rtl/core/sine_stepper_position_follower.sv */
// ----------------------------------------------------------------------------
// Sine stepper position follower
// Turns timer ticks into single microstep requests that follow a sine.
// ----------------------------------------------------------------------------
// Each request on the input stream is one timer tick. The block advances its
// phase (sine mode), looks up the sine, scales amplitude and slewed offset
// into a target in microsteps and moves the step counter at most one step
// toward it, returning one result request per tick. Ticks are handled one at
// a time: a new tick is not taken until the last one has run through all its
// states, and the other modes skip the phase divider and phase advance. The
// run time is set by the bit-serial phase divider (one quotient bit per cycle
// over the 32 phase bits) and the bit-serial target multiplier (one bit of the
// 34-bit displacement magnitude per cycle). A finished result sits in the
// output register, so the next tick is accepted while it waits to be taken.
// Configuration writes are always accepted and are meant to happen only
// while no tick is in flight.
module sine_stepper_position_follower
  import ssp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Tick requests. tdata, from bit 0 up: elapsed_us[15:0], pulse_active,
  // slew_tick, zero fill.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  // Result requests. tdata, from bit 0 up: step_dir[1:0], motor_release,
  // sync_level, step_position[21:0], zero fill.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  // Register writes: 0 run_mode, 1 freq_centihz, 2 amp_decimm,
  // 3 offset_target_halfmm.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int MCNT_W = $clog2(MAG_W);

  // Configuration registers.
  run_mode_t                 run_mode;
  logic [FREQ_W-1:0]         freq_centihz;
  logic [AMP_W-1:0]          amp_decimm;
  logic signed [OFS_W-1:0]   ofs_target;

  // Architectural state.
  logic [PHASE_BITS-1:0]     phase_acc;
  logic signed [OFSNOW_W-1:0] offset_now;
  logic signed [COUNT_W-1:0] step_count;

  // Per-tick working registers.
  state_t                    state;
  state_t                    state_next;
  logic                      pulse_q;
  logic signed [SINE_W-1:0]  sine;
  logic signed [DISP_W-1:0]  disp;
  logic                      neg;
  logic [K_W-1:0]            acc_hi;
  logic [MAG_W-1:0]          acc_lo;
  logic [MCNT_W-1:0]         mcnt;
  logic signed [TGT_W-1:0]   target;
  logic [1:0]                dir;

  // Handshake and control.
  logic                      in_take;
  logic                      div_start;
  logic                      div_done;
  logic [PHASE_BITS-1:0]     div_quot;
  logic                      out_load;

  logic [ELAPSED_W-1:0]      in_elapsed;
  logic                      in_pulse;
  logic                      in_slew;
  logic [PROD_W-1:0]         in_prod;

  assign in_elapsed = s_axis_tdata[15:0];
  assign in_pulse   = s_axis_tdata[16];
  assign in_slew    = s_axis_tdata[17];
  assign in_prod    = PROD_W'(freq_centihz) * PROD_W'(in_elapsed);
  assign in_take    = s_axis_tvalid && s_axis_tready;
  assign cfg_ready  = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration writes, saturated to their legal ranges.
  // ---------------------------------------------------------------------------
  logic [FREQ_W-1:0]       cfg_freq;
  logic [AMP_W-1:0]        cfg_amp;
  logic signed [OFS_W-1:0] cfg_ofs;

  assign cfg_freq = cfg_data[FREQ_W-1:0];
  assign cfg_amp  = cfg_data[AMP_W-1:0];
  assign cfg_ofs  = signed'(cfg_data[OFS_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode     <= MODE_SINE;
      freq_centihz <= FREQ_RESET;
      amp_decimm   <= AMP_RESET;
      ofs_target   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RUN_MODE: run_mode <= run_mode_t'(cfg_data[MODE_W-1:0]);
        REG_FREQ:     freq_centihz <= (cfg_freq > FREQ_TOP) ? FREQ_TOP : cfg_freq;
        REG_AMP:      amp_decimm <= (cfg_amp > AMP_MAX) ? AMP_MAX : cfg_amp;
        REG_OFFSET: begin
          if (cfg_ofs > OFS_LIM_POS) begin
            ofs_target <= OFS_LIM_POS;
          end else if (cfg_ofs < OFS_LIM_NEG) begin
            ofs_target <= OFS_LIM_NEG;
          end else begin
            ofs_target <= cfg_ofs;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Phase increment: freq * elapsed divided by 10^8, one bit per cycle.
  // ---------------------------------------------------------------------------
  ssp_phase_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (in_prod),
    .done     (div_done),
    .quot     (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = (run_mode == MODE_SINE) ? ST_DIV : ST_LOOKUP;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_ADV;
        end
      end
      ST_ADV:    state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_ABS;
      ST_ABS:    state_next = ST_MUL;
      ST_MUL: begin
        if (mcnt == MCNT_W'(MAG_W - 1)) begin
          state_next = ST_SIGN;
        end
      end
      ST_SIGN:   state_next = ST_STEP;
      ST_STEP:   state_next = ST_DONE;
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    div_start     = (state == ST_IDLE) && s_axis_tvalid && (run_mode == MODE_SINE);
    out_load      = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Offset slew, applied on acceptance so the tick's target already sees it.
  // The goal in 0.02 mm units is the half-millimetre target times 25.
  // ---------------------------------------------------------------------------
  logic signed [OFSNOW_W-1:0] ofs_ext;
  logic signed [OFSNOW_W-1:0] ofs_goal;

  assign ofs_ext  = OFSNOW_W'(ofs_target);
  assign ofs_goal = (ofs_ext <<< 4) + (ofs_ext <<< 3) + ofs_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_now <= '0;
    end else if (in_take && in_slew) begin
      if (offset_now < ofs_goal) begin
        offset_now <= offset_now + 1'b1;
      end else if (offset_now > ofs_goal) begin
        offset_now <= offset_now - 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Phase accumulator.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (state == ST_ADV) begin
      phase_acc <= phase_acc + div_quot;
    end
  end

  // ---------------------------------------------------------------------------
  // Sine lookup from the quarter-wave table. Odd quadrants read the table
  // mirrored; the mirror of entry zero is the peak, which lies just past the
  // end of the table. The second half of the turn is negated.
  // ---------------------------------------------------------------------------
  logic [IDX_BITS-1:0] sine_idx;
  logic [1:0]          quad;
  logic [QTR_BITS-1:0] qlow;
  logic [QTR_BITS-1:0] qsel;
  logic [14:0]         sine_mag;
  logic signed [SINE_W-1:0] sine_pos;

  always_comb begin
    sine_idx = phase_acc[PHASE_BITS-1 -: IDX_BITS];
    quad     = sine_idx[IDX_BITS-1 -: 2];
    qlow     = sine_idx[QTR_BITS-1:0];
    qsel     = quad[0] ? (~qlow + 1'b1) : qlow;
    if (quad[0] && (qlow == '0)) begin
      sine_mag = SINE_PEAK;
    end else begin
      sine_mag = SINE_QTR[qsel];
    end
    sine_pos = signed'({1'b0, sine_mag});
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOKUP) begin
      sine <= quad[1] ? -sine_pos : sine_pos;
    end
  end

  // ---------------------------------------------------------------------------
  // Displacement in 0.02 mm * 2^-15: amp * 5 * sine + offset * 2^15, with one
  // full unit added to the sine for an active pulse in pulse mode. Drive to
  // zero uses a zero displacement.
  // ---------------------------------------------------------------------------
  logic [AMP_W+1:0]          amp5;
  logic signed [AMP_W+2:0]   amp5_s;
  logic signed [SINE_W+1:0]  sine_ext;
  logic signed [DISP_W-1:0]  amp_term;
  logic signed [DISP_W-1:0]  ofs_term;
  logic signed [DISP_W-1:0]  disp_mag;

  always_comb begin
    amp5     = ({2'b00, amp_decimm} << 2) + {2'b00, amp_decimm};
    amp5_s   = signed'({1'b0, amp5});
    sine_ext = (SINE_W + 2)'(sine);
    if ((run_mode == MODE_PULSE) && pulse_q) begin
      sine_ext = sine_ext + 18'sd32768;
    end
    amp_term = DISP_W'(amp5_s) * DISP_W'(sine_ext);
    ofs_term = {{(DISP_W - OFSNOW_W - 15){offset_now[OFSNOW_W-1]}}, offset_now, 15'b0};
    disp_mag = disp[DISP_W-1] ? -disp : disp;
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pulse_q <= in_pulse;
    end
    if (state == ST_SCALE) begin
      disp <= (run_mode == MODE_ZERO) ? '0 : (amp_term + ofs_term);
    end
  end

  // ---------------------------------------------------------------------------
  // Target magnitude |D| * TGT_K >> TGT_SHIFT, by a serial-parallel multiplier:
  // one bit of |D| per cycle, LSB first, against the constant. The low product
  // bits shift into acc_lo as the multiplier bits leave it.
  // ---------------------------------------------------------------------------
  logic [K_W:0]    psum;
  logic [MQ_W-1:0] mq;

  assign psum = {1'b0, acc_hi} + (acc_lo[0] ? {1'b0, TGT_K} : '0);
  assign mq   = {acc_hi, acc_lo[MAG_W-1 -: (MAG_W - TGT_SHIFT)]};

  always_ff @(posedge clk) begin
    unique case (state)
      ST_ABS: begin
        neg    <= disp[DISP_W-1];
        acc_lo <= disp_mag[MAG_W-1:0];
        acc_hi <= '0;
        mcnt   <= '0;
      end
      ST_MUL: begin
        acc_hi <= psum[K_W:1];
        acc_lo <= {psum[0], acc_lo[MAG_W-1:1]};
        mcnt   <= mcnt + 1'b1;
      end
      ST_SIGN: begin
        target <= neg ? -signed'({1'b0, mq}) : signed'({1'b0, mq});
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Step decision with one step of hysteresis: forward when the counter lies
  // below the target, backward when it lies more than one step above it.
  // The counter never leaves its signed range. A released motor holds.
  // ---------------------------------------------------------------------------
  logic signed [COUNT_W:0]   count_dec;
  logic signed [CMP_W-1:0]   pos_now;
  logic signed [CMP_W-1:0]   pos_dec;
  logic signed [CMP_W-1:0]   tgt_ext;
  logic                      below;
  logic                      above;

  always_comb begin
    count_dec = (COUNT_W + 1)'(step_count) - 1'b1;
    pos_now   = {{(CMP_W - COUNT_W - 16){step_count[COUNT_W-1]}}, step_count, 16'b0};
    pos_dec   = {{(CMP_W - COUNT_W - 17){count_dec[COUNT_W]}}, count_dec, 16'b0};
    tgt_ext   = CMP_W'(target);
    below     = pos_now < tgt_ext;
    above     = pos_dec > tgt_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= '0;
    end else if ((state == ST_STEP) && (run_mode != MODE_RELEASE)) begin
      if (below) begin
        if (step_count != COUNT_MAX) begin
          step_count <= step_count + 1'b1;
        end
      end else if (above) begin
        if (step_count != COUNT_MIN) begin
          step_count <= step_count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_STEP) begin
      dir <= DIR_HOLD;
      if (run_mode != MODE_RELEASE) begin
        if (below) begin
          if (step_count != COUNT_MAX) begin
            dir <= DIR_FWD;
          end
        end else if (above) begin
          if (step_count != COUNT_MIN) begin
            dir <= DIR_BACK;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. It is loaded once the previous result has been taken.
  // ---------------------------------------------------------------------------
  logic sync_now;
  logic release_now;

  assign sync_now    = !sine[SINE_W-1] && (sine != '0);
  assign release_now = (run_mode == MODE_RELEASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {6'b0, step_count, sync_now, release_now, dir};
    end
  end

endmodule

/* rtl/core/ssp_phase_div.sv */
// ----------------------------------------------------------------------------
// Phase increment divider
// Restoring division by a constant, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssp_phase_div
  import ssp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [PROD_W-1:0]     dividend,
  output logic                  done,
  output logic [PHASE_BITS-1:0] quot
);

  localparam int DCNT_W = $clog2(PHASE_BITS);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [REM_W-1:0]  rem;
  logic [REM_W:0]    rem_sh;
  logic [REM_W:0]    rem_sub;
  logic              ge;

  assign rem_sh  = {rem, 1'b0};
  assign ge      = rem_sh >= {1'b0, PHASE_DIVISOR};
  assign rem_sub = ge ? (rem_sh - {1'b0, PHASE_DIVISOR}) : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(PHASE_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= REM_W'(dividend);
      quot <= '0;
    end else if (busy) begin
      rem  <= rem_sub[REM_W-1:0];
      quot <= {quot[PHASE_BITS-2:0], ge};
    end
  end

endmodule
